>>> sv/cddc_pkg.sv
// Shared types, constants and calendar helper functions for the date converter.
// No dependencies; every other file of the block imports this package.
package cddc_pkg;

  // Largest calendar year that the block reports or accepts.
  localparam int MaxYear = 4095;
  localparam int YearFieldMax = 4095;
  localparam int YearLimInt = (MaxYear > YearFieldMax) ? YearFieldMax : MaxYear;

  localparam int EpochYearInt = 1970;

  // The year walk runs one past the limit, so the counter has one spare bit.
  localparam int YearW = 13;

  localparam logic [YearW-1:0] EPOCH_YEAR = YearW'(EpochYearInt);
  localparam logic [YearW-1:0] YEAR_LIM   = YearW'(YearLimInt);

  // Residues of the epoch year, used to seed the leap-year counters.
  localparam logic [1:0] EPOCH_MOD4   = 2'(EpochYearInt % 4);
  localparam logic [6:0] EPOCH_MOD100 = 7'(EpochYearInt % 100);
  localparam logic [8:0] EPOCH_MOD400 = 9'(EpochYearInt % 400);

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic ACTION_TO_COUNT = 1'b0;
  localparam logic ACTION_TO_DATE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [19:0] in_day_count;
  } in_beat_t;

  typedef struct packed {
    logic [19:0] out_day_count;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic        valid_res;
  } out_beat_t;

  // Control from the sequencer to the year tracker.
  typedef struct packed {
    logic load;
    logic step;
  } cal_ctl_t;

  // Control from the sequencer to the shared add/subtract unit.
  typedef struct packed {
    logic       sub;
    logic [8:0] operand;
  } alu_ctl_t;

  function automatic logic [8:0] year_len(input logic leap);
    year_len = leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    month_len = len;
  endfunction

endpackage

>>> sv/cddc_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on cddc_pkg for the beat payload types.
interface cddc_in_if import cddc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cddc_out_if import cddc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/cddc_alu.sv
// Shared 20-bit add/subtract unit with a greater-or-equal flag.
// Depends on cddc_pkg for the control struct.
module cddc_alu import cddc_pkg::*; (
  input  logic [19:0] acc_i,
  input  alu_ctl_t    ctl_i,
  output logic [19:0] res_o,
  output logic        ge_o
);

  logic [20:0] diff;
  logic [19:0] sum;

  assign diff  = {1'b0, acc_i} - {12'd0, ctl_i.operand};
  assign sum   = acc_i + {11'd0, ctl_i.operand};
  assign ge_o  = ~diff[20];
  assign res_o = ctl_i.sub ? diff[19:0] : sum;

endmodule

>>> sv/cddc_cal.sv
// Year tracker: current year of the walk and its leap flag from residue counters.
// Depends on cddc_pkg for widths, epoch constants and the control struct.
module cddc_cal import cddc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cal_ctl_t         ctl_i,
  output logic [YearW-1:0] year_o,
  output logic             leap_o
);

  logic [YearW-1:0] year_q, year_d;
  logic [1:0]       mod4_q, mod4_d;
  logic [6:0]       mod100_q, mod100_d;
  logic [8:0]       mod400_q, mod400_d;

  always_comb begin
    year_d   = year_q;
    mod4_d   = mod4_q;
    mod100_d = mod100_q;
    mod400_d = mod400_q;
    if (ctl_i.load) begin
      year_d   = EPOCH_YEAR;
      mod4_d   = EPOCH_MOD4;
      mod100_d = EPOCH_MOD100;
      mod400_d = EPOCH_MOD400;
    end else if (ctl_i.step) begin
      year_d   = year_q + YearW'(1);
      mod4_d   = mod4_q + 2'd1;
      mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
      mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= EPOCH_YEAR;
      mod4_q   <= EPOCH_MOD4;
      mod100_q <= EPOCH_MOD100;
      mod400_q <= EPOCH_MOD400;
    end else begin
      year_q   <= year_d;
      mod4_q   <= mod4_d;
      mod100_q <= mod100_d;
      mod400_q <= mod400_d;
    end
  end

  assign year_o = year_q;
  assign leap_o = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

endmodule

>>> sv/calendar_date_day_count_converter_core.sv
// Gregorian date <-> day count since 1970-01-01, one year or one month per cycle.
// The sequencer walks the years, then the months, through the shared adder for
// either action; the year walk takes up most of the time. A date rejected on
// sight skips both walks and goes straight to the finish state. A new item is
// taken only once the last one is through; the next item is taken while a
// result waits. Reset (asynchronous, active low) returns the sequencer to idle
// and empties the result register; no clearing pass is needed.
module calendar_date_day_count_converter_core import cddc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cddc_in_if.sink    in_i,
  cddc_out_if.source out_o
);

  // Sequencer states. The year walk comes first, then the month walk, and the
  // finish state waits for the result register to be free.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_YEAR  = 2'd1;
  localparam logic [1:0] S_MONTH = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]  state_q, state_d;
  logic        action_q, action_d;
  logic [11:0] tyear_q, tyear_d;
  logic [3:0]  tmonth_q, tmonth_d;
  logic [4:0]  tday_q, tday_d;
  logic [19:0] acc_q, acc_d;
  logic [3:0]  mon_q, mon_d;
  logic        ok_q, ok_d;

  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, out_d;

  cal_ctl_t         cal_ctl;
  logic [YearW-1:0] cal_year;
  logic             cal_leap;

  alu_ctl_t    alu_ctl;
  logic [19:0] alu_res;
  logic        alu_ge;

  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        in_beat;
  logic        pre_ok;
  logic        out_free;

  cddc_cal u_cal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cal_ctl),
    .year_o (cal_year),
    .leap_o (cal_leap)
  );

  cddc_alu u_alu (
    .acc_i (acc_q),
    .ctl_i (alu_ctl),
    .res_o (alu_res),
    .ge_o  (alu_ge)
  );

  assign ylen     = year_len(cal_leap);
  assign mlen     = month_len(mon_q, cal_leap);
  assign in_i.ready = (state_q == S_IDLE);
  assign in_beat  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // Checks that need no walk: year range, month range and a nonzero day. The
  // day against the month length is checked once the walk reaches that year and month.
  assign pre_ok = ({1'b0, in_i.data.in_year} >= EPOCH_YEAR) &&
                  ({1'b0, in_i.data.in_year} <= YEAR_LIM) &&
                  (in_i.data.in_month >= MONTH_JAN) &&
                  (in_i.data.in_month <= MONTH_DEC) &&
                  (in_i.data.in_day != 5'd0);

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    tyear_d     = tyear_q;
    tmonth_d    = tmonth_q;
    tday_d      = tday_q;
    acc_d       = acc_q;
    mon_d       = mon_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cal_ctl     = '0;
    alu_ctl.sub = (action_q == ACTION_TO_DATE);
    alu_ctl.operand = ylen;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          action_d     = in_i.data.action;
          tyear_d      = in_i.data.in_year;
          tmonth_d     = in_i.data.in_month;
          tday_d       = in_i.data.in_day;
          acc_d        = (in_i.data.action == ACTION_TO_DATE) ? in_i.data.in_day_count : '0;
          mon_d        = MONTH_JAN;
          cal_ctl.load = 1'b1;
          if ((in_i.data.action == ACTION_TO_COUNT) && !pre_ok) begin
            ok_d    = 1'b0;
            state_d = S_FIN;
          end else begin
            state_d = S_YEAR;
          end
        end
      end
      S_YEAR: begin
        alu_ctl.operand = ylen;
        if (action_q == ACTION_TO_COUNT) begin
          if (cal_year < {1'b0, tyear_q}) begin
            acc_d        = alu_res;
            cal_ctl.step = 1'b1;
          end else begin
            state_d = S_MONTH;
          end
        end else begin
          if ((cal_year <= YEAR_LIM) && alu_ge) begin
            acc_d        = alu_res;
            cal_ctl.step = 1'b1;
          end else if (cal_year <= YEAR_LIM) begin
            state_d = S_MONTH;
          end else begin
            ok_d    = 1'b0;
            state_d = S_FIN;
          end
        end
      end
      S_MONTH: begin
        if (action_q == ACTION_TO_COUNT) begin
          if (mon_q < tmonth_q) begin
            alu_ctl.operand = {4'd0, mlen};
            acc_d           = alu_res;
            mon_d           = mon_q + 4'd1;
          end else begin
            // Here the month counter equals the requested month.
            alu_ctl.operand = {4'd0, tday_q - 5'd1};
            if (tday_q <= mlen) begin
              acc_d = alu_res;
              ok_d  = 1'b1;
            end else begin
              ok_d = 1'b0;
            end
            state_d = S_FIN;
          end
        end else begin
          alu_ctl.operand = {4'd0, mlen};
          if ((mon_q < MONTH_DEC) && alu_ge) begin
            acc_d = alu_res;
            mon_d = mon_q + 4'd1;
          end else begin
            ok_d    = 1'b1;
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (ok_q) begin
            out_d.valid_res = 1'b1;
            if (action_q == ACTION_TO_COUNT) begin
              out_d.out_day_count = acc_q;
            end else begin
              out_d.out_year  = cal_year[11:0];
              out_d.out_month = mon_q;
              out_d.out_day   = acc_q[4:0] + 5'd1;
            end
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    tyear_q  <= tyear_d;
    tmonth_q <= tmonth_d;
    tday_q   <= tday_d;
    acc_q    <= acc_d;
    mon_q    <= mon_d;
    ok_q     <= ok_d;
    out_q    <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

>>> tb/sv/calendar_date_day_count_converter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Gregorian date / epoch day count converter core.
// Depends on cddc_pkg, the cddc_in_if / cddc_out_if channels and the core module.
module calendar_date_day_count_converter_core_tb;
  import cddc_pkg::*;

  // One queued request: the beat itself, and whether the sender must first wait
  // until every earlier conversion has come back.
  typedef struct {
    in_beat_t beat;
    bit       drain_first;
  } conversion_request_t;

  logic clk_i;
  logic rst_ni;

  cddc_in_if  in_if ();
  cddc_out_if out_if ();

  calendar_date_day_count_converter_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  conversion_request_t conversion_requests[$];
  out_beat_t           predicted_results[$];

  int  mismatch_count = 0;
  // Set at the rising edge that accepts an input beat, consumed by the driver at the
  // following falling edge, so the driver never looks at ready after it has moved.
  bit  beat_taken = 1'b0;
  int  burst_left = 1;
  int  gap_left = 0;
  int  ready_phase_left = 0;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the prediction. Leap years follow the Gregorian rule,
  // and February's length is worked out for the year at hand every time.
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned year_days(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    case (m)
      2:       return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Day count of a date that is already known to be valid.
  function automatic int unsigned day_count_of(int unsigned y, int unsigned m,
                                               int unsigned d);
    int unsigned total;
    total = 0;
    for (int unsigned yy = EpochYearInt; yy < y; yy++) total += year_days(yy);
    for (int unsigned mm = 1; mm < m; mm++) total += days_in_month(mm, y);
    return total + d - 1;
  endfunction

  // Expected result beat for one input beat. Every field of an invalid result is
  // zero, and the fields that one action does not produce stay zero as well.
  function automatic out_beat_t convert_beat(in_beat_t b);
    out_beat_t   r;
    int unsigned y, m, d, left;
    r = '0;
    if (b.action == ACTION_TO_COUNT) begin
      y = b.in_year;
      m = b.in_month;
      d = b.in_day;
      if (y >= EpochYearInt && y <= YearLimInt && m >= 1 && m <= 12 &&
          d >= 1 && d <= days_in_month(m, y)) begin
        r.out_day_count = 20'(day_count_of(y, m, d));
        r.valid_res = 1'b1;
      end
    end else begin
      // Walk the years, stopping once the year passes the limit.
      left = b.in_day_count;
      y = EpochYearInt;
      while (y <= YearLimInt && left >= year_days(y)) begin
        left -= year_days(y);
        y++;
      end
      if (y <= YearLimInt) begin
        m = 1;
        while (m < 12 && left >= days_in_month(m, y)) begin
          left -= days_in_month(m, y);
          m++;
        end
        r.out_year = 12'(y);
        r.out_month = 4'(m);
        r.out_day = 5'(left + 1);
        r.valid_res = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders. Fields that the chosen action ignores carry random noise so
  // that every input bit toggles and the block is seen to ignore them.
  // ---------------------------------------------------------------------------
  task automatic push_date(int unsigned y, int unsigned m, int unsigned d,
                           bit drain_first = 1'b0);
    conversion_request_t req;
    req.beat.action = ACTION_TO_COUNT;
    req.beat.in_year = 12'(y);
    req.beat.in_month = 4'(m);
    req.beat.in_day = 5'(d);
    req.beat.in_day_count = 20'($urandom());
    req.drain_first = drain_first;
    conversion_requests.push_back(req);
  endtask

  task automatic push_count(int unsigned c, bit drain_first = 1'b0);
    conversion_request_t req;
    req.beat.action = ACTION_TO_DATE;
    req.beat.in_year = 12'($urandom());
    req.beat.in_month = 4'($urandom());
    req.beat.in_day = 5'($urandom());
    req.beat.in_day_count = 20'(c);
    req.drain_first = drain_first;
    conversion_requests.push_back(req);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is held from the start and released on a falling edge,
  // away from the edge at which the block samples.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    fork
      forever #5 clk_i = ~clk_i;
      begin
        repeat (12) @(negedge clk_i);
        rst_ni = 1'b1;
      end
    join_none
  end

  // ---------------------------------------------------------------------------
  // Driver. It works in bursts of random length separated by random gaps, and a
  // request marked drain_first is held back until no result is outstanding.
  // The valid and data values are settled in local variables and written once per
  // falling edge, so back-to-back beats never see valid lowered and raised again.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    logic                next_valid;
    in_beat_t            next_data;
    conversion_request_t req;
    next_valid = in_if.valid;
    next_data = in_if.data;
    if (beat_taken) begin
      next_valid = 1'b0;
      beat_taken = 1'b0;
    end
    if (rst_ni && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (conversion_requests.size() > 0 &&
                   !(conversion_requests[0].drain_first && predicted_results.size() > 0)) begin
        req = conversion_requests.pop_front();
        next_data = req.beat;
        next_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          // Now and then a long burst, otherwise a short one; now and then no gap at all.
          burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end
    in_if.valid <= next_valid;
    in_if.data <= next_data;
  end

  // ---------------------------------------------------------------------------
  // Receiver. Ready alternates between runs high and stalls low, on a pattern that
  // has nothing to do with the sender; some high runs are long enough that whole
  // stretches of results pass without a stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (ready_phase_left > 0) begin
      ready_phase_left--;
    end else if (out_if.ready) begin
      ready_phase_left = $urandom_range(0, 24);
      out_if.ready <= 1'b0;
    end else begin
      ready_phase_left = ($urandom_range(3) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(0, 12);
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge a result beat is checked against the oldest
  // prediction first; an input beat taken at the same edge cannot have produced it,
  // so its prediction is queued only afterwards.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_beat_t want;
    out_beat_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result beat with nothing outstanding: %p", $realtime, got);
        end else begin
          want = predicted_results.pop_front();
          check_field("out_day_count", want.out_day_count, got.out_day_count);
          check_field("out_year", want.out_year, got.out_year);
          check_field("out_month", want.out_month, got.out_month);
          check_field("out_day", want.out_day, got.out_day);
          check_field("valid_res", want.valid_res, got.valid_res);
        end
      end
      if (in_if.valid && in_if.ready) begin
        predicted_results.push_back(convert_beat(in_if.data));
        beat_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned last_count;
    int unsigned y, m, d, pick;
    last_count = day_count_of(YearLimInt, MONTH_DEC, 31);

    // Directed part: both ends of the calendar, every rejection reason, and the
    // leap-year rule with its century exceptions, in both directions.
    push_date(EpochYearInt, MONTH_JAN, 1);
    push_date(YearLimInt, MONTH_DEC, 31);
    push_date(EpochYearInt - 1, MONTH_DEC, 31);       // year below the epoch
    push_date(0, 0, 0);
    push_date(2000, MONTH_FEB, 29);                     // leap by the 400 rule
    push_date(2100, MONTH_FEB, 29);                     // century, not a leap year
    push_date(2100, MONTH_FEB, 28, 1'b1);
    push_date(2024, MONTH_FEB, 29);
    push_date(2023, MONTH_FEB, 29);
    push_date(1980, 4, 31);                             // day past the end of April
    push_date(1980, 4, 30);
    push_date(2000, 13, 1);                             // month out of range
    push_date(2000, 15, 31);
    push_date(2000, MONTH_DEC, 0);                      // day zero
    push_date(2000, MONTH_DEC, 31);
    push_count(0);
    push_count(364);
    push_count(365);
    push_count(day_count_of(1972, MONTH_FEB, 29));
    push_count(day_count_of(2000, MONTH_DEC, 31));      // last day of a leap year
    push_count(last_count);
    push_count(last_count + 1);                         // year walks past the limit
    push_count(20'hFFFFF);

    // Random part. Most items stay within a couple of centuries of the epoch so the
    // year walk is short; a minority spans the whole range up to the limit.
    for (int n = 0; n < 250; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(1) == 0) begin
        if (pick < 75) y = $urandom_range(EpochYearInt, 2100);
        else if (pick < 88) y = $urandom_range(EpochYearInt, YearLimInt);
        else y = $urandom_range(0, 4095);
        m = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        if ($urandom_range(99) < 15 || m < 1 || m > 12)
          d = $urandom_range(0, 31);
        else
          d = $urandom_range(1, days_in_month(m, y));
        push_date(y, m, d, n % 90 == 0);
      end else begin
        if (pick < 75) push_count($urandom_range(0, 60000), n % 90 == 0);
        else if (pick < 90) push_count($urandom_range(0, last_count + 400), n % 90 == 0);
        else push_count($urandom_range(0, 20'hFFFFF), n % 90 == 0);
      end
    end

    // Wait for the driver to hand over every request, then for every result.
    while (conversion_requests.size() > 0 || in_if.valid) @(posedge clk_i);
    while (predicted_results.size() > 0) @(posedge clk_i);
    // One full worst-case conversion time for any stray result to show up.
    repeat (2200) @(posedge clk_i);
    if (predicted_results.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a fifth of this.
  initial begin : watchdog
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
